/* rtl/gcd_pkg.sv */
// Shared types, constants and arctangent table functions for the great-circle distance block.
package gcd_pkg;

  typedef logic signed [63:0] q61_t;

  localparam logic signed [31:0] FULL_TURN_HD    = 32'sd754974720;
  localparam logic signed [31:0] HALF_TURN_HD    = 32'sd377487360;
  localparam logic signed [31:0] QUARTER_TURN_HD = 32'sd188743680;
  localparam logic [34:0]        DEG_TO_RAD_Q40  = 35'd19190098069;
  localparam q61_t               GAIN_INV_Q61    = 64'sd1400229934994268173;
  localparam logic [62:0]        Q62_ONE         = 63'd1 << 62;
  localparam logic [23:0]        RADIUS_RESET    = 24'd6366198;
  localparam int                 SQRT_STEPS      = 32;

  // bit-serial long division, used at elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [63:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(1/n) in Q61 by its Taylor series with floored terms
  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] sum;
    p   = udiv(64'd1 << 61, n);
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (p != '0) begin
        t = udiv(p, 64'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else      sum = sum + t;
        p = udiv(udiv(p, n), n);
      end
    end
    return sum;
  endfunction

  function automatic q61_t atan_q61(input int i);
    if (i == 0) return $signed(atan_recip(64'd2) + atan_recip(64'd3));
    return $signed(atan_recip(64'd1 << i));
  endfunction

endpackage

/* rtl/great_circle_distance.sv */
// Throughput: one item per cycle unless the output stalls; every stage is a register,
// one item per stage. The depth is set by the sine/cosine CORDIC row, the 32-cell
// square-root row and the vectoring CORDIC row; a stalled output holds the row and
// empty stages still fill.
// Reset clears every stage's valid flag and loads the sphere radius with 6366198 m.
module great_circle_distance #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [29:0] first_longitude_i,
  input  logic signed [27:0] first_latitude_i,
  input  logic signed [29:0] second_longitude_i,
  input  logic signed [27:0] second_latitude_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        central_angle_o,
  output logic [33:0]        surface_distance_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [23:0]        cfg_data_i
);
  import gcd_pkg::*;

  localparam int N       = CORDIC_STAGES;
  // stage map
  localparam int ST_RED  = 0;              // reduce and fold half angles
  localparam int ST_MUL  = 1;              // partial products to radians
  localparam int ST_Z    = 2;              // sum partial products
  localparam int ST_ROT  = 3;              // sine/cosine CORDIC row
  localparam int ST_FLIP = ST_ROT + N;     // undo fold, drop to Q31
  localparam int ST_SQ   = ST_FLIP + 1;    // sin^2(dlat/2), cos1*cos2
  localparam int ST_T1   = ST_SQ + 1;
  localparam int ST_T2   = ST_T1 + 1;
  localparam int ST_SUM  = ST_T2 + 1;      // a, clamped
  localparam int ST_CMP  = ST_SUM + 1;     // a and 1-a
  localparam int ST_SQRT = ST_CMP + 1;     // square-root row
  localparam int ST_VEC  = ST_SQRT + SQRT_STEPS; // vectoring CORDIC row
  localparam int ST_ANG  = ST_VEC + N;
  localparam int ST_OUT  = ST_ANG + 1;
  localparam int NSTG    = ST_OUT + 1;

  localparam logic signed [18:0] DR_LO = {1'b0, DEG_TO_RAD_Q40[17:0]};
  localparam logic signed [17:0] DR_HI = {1'b0, DEG_TO_RAD_Q40[34:18]};

  typedef struct packed {
    logic              flip;
    logic signed [28:0] ang;
  } fold_t;

  // reduce to one turn, then fold into [-90,90] degrees; a fold negates sin and cos
  function automatic fold_t fold_angle(input logic signed [31:0] hd);
    logic signed [31:0] t;
    fold_t f;
    t = hd;
    if (t < 0) t = t + FULL_TURN_HD;
    if (t < 0) t = t + FULL_TURN_HD;
    if (t >= FULL_TURN_HD) t = t - FULL_TURN_HD;
    if (t >= HALF_TURN_HD) t = t - FULL_TURN_HD;
    f.flip = 1'b0;
    if (t > QUARTER_TURN_HD) begin
      t      = t - HALF_TURN_HD;
      f.flip = 1'b1;
    end else if (t < -QUARTER_TURN_HD) begin
      t      = t + HALF_TURN_HD;
      f.flip = 1'b1;
    end
    f.ang = t[28:0];
    return f;
  endfunction

  // ---------------------------------------------------------------- flow control
  // A stage loads when the row advances or when it is empty, so bubbles close up
  // behind a stalled output without any ripple through the row.
  logic [NSTG-1:0] vld_q, vld_d, load, leave, vprev;
  logic            adv;

  assign adv         = !vld_q[NSTG-1] || out_ready_i;
  assign load        = {NSTG{adv}} | ~vld_q;
  assign leave       = {out_ready_i, load[NSTG-1:1]};
  assign vprev       = {vld_q[NSTG-2:0], in_valid_i};
  assign vld_d       = (load & vprev) | (~load & ~leave & vld_q);
  assign in_ready_o  = load[ST_RED];
  assign out_valid_o = vld_q[NSTG-1];

  logic [23:0] radius_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      radius_q <= RADIUS_RESET;
    end else begin
      vld_q <= vld_d;
      if (cfg_valid_i) radius_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- front end
  // angle order: dlat/2, dlon/2, lat1, lat2, all in 2^-21 degree units
  logic signed [31:0] hd [4];
  fold_t              red_q [4];
  logic signed [47:0] mlo_q [4];
  logic signed [46:0] mhi_q [4];
  logic [3:0]         mflip_q, zflip_q;
  q61_t               z_q [4];

  assign hd[0] = 32'(second_latitude_i) - 32'(first_latitude_i);
  assign hd[1] = 32'(second_longitude_i) - 32'(first_longitude_i);
  assign hd[2] = 32'(first_latitude_i) <<< 1;
  assign hd[3] = 32'(second_latitude_i) <<< 1;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 4; a++) begin
      if (load[ST_RED]) red_q[a] <= fold_angle(hd[a]);
      if (load[ST_MUL]) begin
        mlo_q[a]   <= red_q[a].ang * DR_LO;
        mhi_q[a]   <= red_q[a].ang * DR_HI;
        mflip_q[a] <= red_q[a].flip;
      end
      if (load[ST_Z]) begin
        z_q[a]     <= (mhi_q[a] <<< 18) + mlo_q[a];
        zflip_q[a] <= mflip_q[a];
      end
    end
  end

  // ---------------------------------------------------------------- sine/cosine row
  q61_t       rx [4][N+1];
  q61_t       ry [4][N+1];
  q61_t       rz [4][N+1];
  logic [3:0] rflip_q [N];

  for (genvar a = 0; a < 4; a++) begin : g_trig
    assign rx[a][0] = GAIN_INV_Q61;
    assign ry[a][0] = '0;
    assign rz[a][0] = z_q[a];
    for (genvar j = 0; j < N; j++) begin : g_cell
      gcd_cordic_cell #(.IDX(j), .VECTOR(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (load[ST_ROT+j]),
        .x_i   (rx[a][j]),
        .y_i   (ry[a][j]),
        .z_i   (rz[a][j]),
        .x_o   (rx[a][j+1]),
        .y_o   (ry[a][j+1]),
        .z_o   (rz[a][j+1])
      );
    end
  end

  // carry the fold flags alongside the row
  always_ff @(posedge clk_i) begin
    if (load[ST_ROT]) rflip_q[0] <= zflip_q;
    for (int j = 1; j < N; j++) begin
      if (load[ST_ROT+j]) rflip_q[j] <= rflip_q[j-1];
    end
  end

  // ---------------------------------------------------------------- haversine sum
  logic signed [33:0] trig_d [4];
  logic signed [33:0] trig_q [4];
  q61_t               trig_w [4];
  q61_t               trig_s [4];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      // sines for the differences, cosines for the latitudes
      trig_w[a] = (a < 2) ? ry[a][N] : rx[a][N];
      if (rflip_q[N-1][a]) trig_w[a] = -trig_w[a];
      trig_s[a] = trig_w[a] >>> 30;
      trig_d[a] = trig_s[a][33:0];
    end
  end

  logic signed [67:0] sq_full, pp_full, t1_full, term_full;
  logic [63:0]        latsq_q, latsq1_q, latsq2_q;
  q61_t               pp_q, pp_sh, t1_q, t1_sh, term_q;
  logic signed [33:0] sl1_q, sl2_q, p_n, q_n;
  logic signed [65:0] a_raw;
  logic [62:0]        sum_d, sum_q, va_q, vb_q;

  assign sq_full   = trig_q[0] * trig_q[0];
  assign pp_full   = trig_q[2] * trig_q[3];
  assign pp_sh     = pp_q >>> 31;
  assign p_n       = pp_sh[33:0];
  assign t1_full   = p_n * sl1_q;
  assign t1_sh     = t1_q >>> 31;
  assign q_n       = t1_sh[33:0];
  assign term_full = q_n * sl2_q;
  assign a_raw     = $signed({2'b00, latsq2_q}) + term_q;

  always_comb begin
    // clamp a into [0,1]
    if (a_raw < 0)                               sum_d = '0;
    else if (a_raw > $signed({3'b000, Q62_ONE})) sum_d = Q62_ONE;
    else                                         sum_d = a_raw[62:0];
  end

  always_ff @(posedge clk_i) begin
    if (load[ST_FLIP]) trig_q <= trig_d;
    if (load[ST_SQ]) begin
      latsq_q <= sq_full[63:0];
      pp_q    <= pp_full[63:0];
      sl1_q   <= trig_q[1];
    end
    if (load[ST_T1]) begin
      latsq1_q <= latsq_q;
      t1_q     <= t1_full[63:0];
      sl2_q    <= sl1_q;
    end
    if (load[ST_T2]) begin
      latsq2_q <= latsq1_q;
      term_q   <= term_full[63:0];
    end
    if (load[ST_SUM]) sum_q <= sum_d;
    if (load[ST_CMP]) begin
      va_q <= sum_q;
      vb_q <= Q62_ONE - sum_q;
    end
  end

  // ---------------------------------------------------------------- square roots
  logic [63:0] sv [2][SQRT_STEPS+1];
  logic [63:0] sr [2][SQRT_STEPS+1];

  assign sv[0][0] = {1'b0, va_q};
  assign sv[1][0] = {1'b0, vb_q};

  for (genvar b = 0; b < 2; b++) begin : g_root
    assign sr[b][0] = '0;
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_cell
      gcd_sqrt_cell #(.IDX(j)) u_cell (
        .clk_i (clk_i),
        .en_i  (load[ST_SQRT+j]),
        .v_i   (sv[b][j]),
        .r_i   (sr[b][j]),
        .v_o   (sv[b][j+1]),
        .r_o   (sr[b][j+1])
      );
    end
  end

  // ---------------------------------------------------------------- atan2 row
  q61_t vx [N+1];
  q61_t vy [N+1];
  q61_t vz [N+1];

  assign vx[0] = {2'b00, sr[1][SQRT_STEPS][31:0], 30'd0};
  assign vy[0] = {2'b00, sr[0][SQRT_STEPS][31:0], 30'd0};
  assign vz[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_vec
    gcd_cordic_cell #(.IDX(j), .VECTOR(1'b1)) u_cell (
      .clk_i (clk_i),
      .en_i  (load[ST_VEC+j]),
      .x_i   (vx[j]),
      .y_i   (vy[j]),
      .z_i   (vz[j]),
      .x_o   (vx[j+1]),
      .y_o   (vy[j+1]),
      .z_o   (vz[j+1])
    );
  end

  // ---------------------------------------------------------------- angle and distance
  logic [31:0] angle_q, ca_q;
  logic [55:0] prod;
  logic [33:0] dist_q;

  assign prod = angle_q * radius_q;

  always_ff @(posedge clk_i) begin
    // drop a slightly negative residue to zero
    if (load[ST_ANG]) angle_q <= vz[N][63] ? '0 : vz[N][61:30];
    if (load[ST_OUT]) begin
      ca_q   <= angle_q;
      dist_q <= prod[55:22];
    end
  end

  assign central_angle_o    = ca_q;
  assign surface_distance_o = dist_q;

endmodule

/* rtl/gcd_cordic_cell.sv */
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered outputs.
module gcd_cordic_cell #(
  parameter int IDX    = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  gcd_pkg::q61_t x_i,
  input  gcd_pkg::q61_t y_i,
  input  gcd_pkg::q61_t z_i,
  output gcd_pkg::q61_t x_o,
  output gcd_pkg::q61_t y_o,
  output gcd_pkg::q61_t z_o
);
  import gcd_pkg::*;

  localparam q61_t ATAN = atan_q61(IDX);

  q61_t dx, dy;
  logic up;
  q61_t x_d, y_d, z_d;
  q61_t x_q, y_q, z_q;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;
  // rotation steers on z, vectoring on the sign of y
  assign up = VECTOR ? !(!y_i[63] && (y_i != '0)) : !z_i[63];

  always_comb begin
    if (up) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

/* rtl/gcd_sqrt_cell.sv */
// One digit step of the restoring integer square root, registered outputs.
module gcd_sqrt_cell #(
  parameter int IDX = 0
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] v_i,
  input  logic [63:0] r_i,
  output logic [63:0] v_o,
  output logic [63:0] r_o
);
  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

  logic [63:0] trial;
  logic [63:0] v_d, r_d, v_q, r_q;

  assign trial = r_i + BIT;

  always_comb begin
    if (v_i >= trial) begin
      v_d = v_i - trial;
      r_d = (r_i >> 1) + BIT;
    end else begin
      v_d = v_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= v_d;
      r_q <= r_d;
    end
  end

  assign v_o = v_q;
  assign r_o = r_q;

endmodule

/* rtl/gcd_checker.sv */
// Port-level assertions for the great-circle distance block, bound to the top level.
module gcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] central_angle_o,
  input logic [33:0] surface_distance_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(central_angle_o)
      && $stable(surface_distance_o))
    else $error("stalled result changed");

  // an empty output stage never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output free");

  a_angle_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> central_angle_o <= 32'd3373259427)
    else $error("central angle beyond half turn");

  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && central_angle_o == '0 |-> surface_distance_o == '0)
    else $error("distance without angle");

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
